### hdl/gras_pkg.sv
// types, constants and helper functions for the gamepad report axis scaler
// no dependencies; used by gamepad_report_axis_scaler

package gras_pkg;

    // field widths
    localparam int BUTTON_W           = 12;
    localparam int NUM_MAPPED_BUTTONS = 12;
    localparam int HAT_W              = 4;
    localparam int RAW_W              = 16;
    localparam int AXIS_W             = 32;
    localparam int ANGLE_W            = 16;
    localparam int PCT_W              = 14;

    // configuration port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEADZONE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SATURATION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 3'd4;

    localparam logic MODE_STANDARD = 1'b0;
    localparam logic MODE_COMBINED = 1'b1;

    localparam logic              MODE_RESET       = MODE_COMBINED;
    localparam logic [PCT_W-1:0]  DEADZONE_RESET   = 14'd0;
    localparam logic [PCT_W-1:0]  SATURATION_RESET = 14'd10000;
    localparam logic [AXIS_W-1:0] RANGE_LOW_RESET  = 32'd0;
    localparam logic [AXIS_W-1:0] RANGE_HIGH_RESET = 32'd65535;

    localparam int PCT_FULL = 10000;
    localparam int HAT_STEP = 4500;

    // datapath widths
    localparam int V_W        = 17;   // raw value measured from the logical centre
    localparam int THR_W      = 18;   // signed split points
    localparam int DIFF_W     = 19;
    localparam int A_W        = 17;   // offset into the linear band
    localparam int MAG_W      = 34;   // magnitude of the physical span
    localparam int DEN_W      = 17;   // width of the linear band
    localparam int BASE_W     = 33;
    localparam int PROD_W     = 51;
    localparam int QUO_W      = 34;
    localparam int REM_W      = 17;
    localparam int SUM_W      = 35;
    localparam int PCT_PROD_W = 30;
    localparam int PCT_Q_W    = 16;
    localparam int LANES      = 5;    // four sticks and the trigger axis
    localparam int DIV_STAGES = QUO_W;

    localparam logic [A_W-1:0]   TRIG_A_HIGH  = 17'd65535;
    localparam logic [A_W-1:0]   TRIG_A_LOW   = 17'd0;
    localparam logic [A_W-1:0]   TRIG_A_MID   = 17'd32768;
    localparam logic [DEN_W-1:0] TRIG_DEN     = 17'd65535;

    // 1/625 scaled by 2**36, exact for 26-bit dividends
    localparam logic [26:0] RECIP_625   = 27'd109951163;
    localparam int          RECIP_SHIFT = 36;

    localparam int STD_BUTTON_MAP [BUTTON_W] = '{1, 2, 0, 3, 4, 5, 8, 9, 10, 11, 6, 7};

    typedef struct packed {
        logic        [BUTTON_W-1:0] button_bits;
        logic signed [HAT_W-1:0]    hat_dir;
        logic signed [RAW_W-1:0]    stick_left_x;
        logic signed [RAW_W-1:0]    stick_left_y;
        logic signed [RAW_W-1:0]    stick_right_x;
        logic signed [RAW_W-1:0]    stick_right_y;
    } report_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0]   axis_x;
        logic signed [AXIS_W-1:0]   axis_y;
        logic signed [AXIS_W-1:0]   axis_z;
        logic signed [AXIS_W-1:0]   axis_rx;
        logic signed [AXIS_W-1:0]   axis_ry;
        logic signed [AXIS_W-1:0]   axis_rz;
        logic        [BUTTON_W-1:0] button_mask;
        logic signed [ANGLE_W-1:0]  hat_angle;
    } result_t;

    typedef struct packed {
        logic        [BUTTON_W-1:0] button_mask;
        logic signed [ANGLE_W-1:0]  hat_angle;
    } side_t;

    typedef struct packed {
        logic        [A_W-1:0]    a;
        logic        [MAG_W-1:0]  mag;
        logic        [DEN_W-1:0]  den;
        logic                     neg;
        logic signed [BASE_W-1:0] base;
    } mul_t;

    typedef struct packed {
        logic        [PROD_W-1:0] prod;
        logic        [DEN_W-1:0]  den;
        logic                     neg;
        logic signed [BASE_W-1:0] base;
    } prod_t;

    typedef struct packed {
        logic        [REM_W-1:0]  rem;
        logic        [QUO_W-1:0]  quo;
        logic        [DEN_W-1:0]  den;
        logic                     neg;
        logic signed [BASE_W-1:0] base;
    } lane_t;

    function automatic logic [BUTTON_W-1:0] map_buttons_std(input logic [BUTTON_W-1:0] btn);
        logic [BUTTON_W-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_MAPPED_BUTTONS && i < BUTTON_W; i++)
        begin
            if (btn[i])
            begin
                m[STD_BUTTON_MAP[i]] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] hat_to_angle(input logic signed [HAT_W-1:0] hat);
        logic signed [ANGLE_W-1:0] ang;
        if (hat[HAT_W-1])
        begin
            ang = -16'sd1;
        end
        else
        begin
            ang = ANGLE_W'(int'(hat[HAT_W-2:0]) * HAT_STEP);
        end
        return ang;
    endfunction

    // floor(x / 10000): drop the factor 16, then reciprocal multiply for 625
    function automatic logic [PCT_Q_W-1:0] div_pct_full(input logic [PCT_PROD_W-1:0] x);
        logic [52:0] p;
        p = {27'b0, x[PCT_PROD_W-1:4]} * {26'b0, RECIP_625};
        return p[RECIP_SHIFT+PCT_Q_W-1:RECIP_SHIFT];
    endfunction

    // one restoring step of the quotient pipeline
    function automatic lane_t div_step(input lane_t l);
        logic [REM_W:0] t;
        lane_t          o;
        o = l;
        t = {l.rem, l.quo[QUO_W-1]};
        if (t >= {1'b0, l.den})
        begin
            o.rem = REM_W'(t - {1'b0, l.den});
            o.quo = {l.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = t[REM_W-1:0];
            o.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic signed [AXIS_W-1:0] finish_lane(input lane_t l);
        logic signed [SUM_W-1:0] q;
        logic signed [SUM_W-1:0] s;
        q = $signed({1'b0, l.quo});
        s = SUM_W'(l.base) + (l.neg ? -q : q);
        return s[AXIS_W-1:0];
    endfunction

endpackage

### hdl/gamepad_report_axis_scaler.sv
// gamepad report axis scaler: deadzone, saturation and linear scaling of stick axes
// depends on gras_pkg (types, constants, division helpers)
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  report    | report_valid, report_ready, report        | in
//  result    | result_valid, result_ready, result        | out
//  config    | psel, penable, pwrite, paddr, pwdata,     | in/out
//            | prdata, pready                            |
//
// one report per cycle while the skid register is empty; the result comes out of the
// 34-stage restoring quotient pipeline shared in shape by all five axis lanes
// reset clears control state and loads the register reset values
// a stalled result parks in a skid register; the pipeline holds only once that is full

module gamepad_report_axis_scaler
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gras_pkg::ADDR_W-1:0]   paddr,
    input  logic [gras_pkg::DATA_W-1:0]   pwdata,
    output logic [gras_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          report_valid,
    output logic                          report_ready,
    input  gras_pkg::report_t             report,
    output logic                          result_valid,
    input  logic                          result_ready,
    output gras_pkg::result_t             result
);

    localparam int LANES      = gras_pkg::LANES;
    localparam int DIV_STAGES = gras_pkg::DIV_STAGES;
    localparam int PIPE_DEPTH = 4 + DIV_STAGES + 1;
    localparam int LAST       = PIPE_DEPTH - 1;

    // configuration registers
    logic                                  mode_reg;
    logic        [gras_pkg::PCT_W-1:0]     dead_reg;
    logic        [gras_pkg::PCT_W-1:0]     sat_reg;
    logic signed [gras_pkg::AXIS_W-1:0]    lo_reg;
    logic signed [gras_pkg::AXIS_W-1:0]    hi_reg;
    logic        [gras_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gras_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= gras_pkg::MODE_RESET;
            dead_reg <= gras_pkg::DEADZONE_RESET;
            sat_reg  <= gras_pkg::SATURATION_RESET;
            lo_reg   <= gras_pkg::RANGE_LOW_RESET;
            hi_reg   <= gras_pkg::RANGE_HIGH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                gras_pkg::REG_MODE:       mode_reg <= pwdata[0];
                gras_pkg::REG_DEADZONE:   dead_reg <= pwdata[gras_pkg::PCT_W-1:0];
                gras_pkg::REG_SATURATION: sat_reg  <= pwdata[gras_pkg::PCT_W-1:0];
                gras_pkg::REG_RANGE_LOW:  lo_reg   <= pwdata;
                gras_pkg::REG_RANGE_HIGH: hi_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gras_pkg::REG_MODE:       prdata = gras_pkg::DATA_W'(mode_reg);
            gras_pkg::REG_DEADZONE:   prdata = gras_pkg::DATA_W'(dead_reg);
            gras_pkg::REG_SATURATION: prdata = gras_pkg::DATA_W'(sat_reg);
            gras_pkg::REG_RANGE_LOW:  prdata = lo_reg;
            gras_pkg::REG_RANGE_HIGH: prdata = hi_reg;
            default:                  prdata = '0;
        endcase
    end

    // split points and physical centre, recomputed every cycle from the registers
    logic        [gras_pkg::PCT_PROD_W-1:0] pct_dn_reg, pct_sn_reg, pct_dp_reg, pct_sp_reg;
    logic        [gras_pkg::PCT_PROD_W-1:0] dead_x32768, sat_x32768;
    logic signed [gras_pkg::THR_W-1:0]      thr_neg_lo_reg, thr_neg_hi_reg;
    logic signed [gras_pkg::THR_W-1:0]      thr_pos_lo_reg, thr_pos_hi_reg;
    logic signed [gras_pkg::BASE_W-1:0]     pctr_reg, pctr_next, sum_lh;

    assign dead_x32768 = {1'b0, dead_reg, 15'b0};
    assign sat_x32768  = {1'b0, sat_reg, 15'b0};
    assign sum_lh      = gras_pkg::BASE_W'(lo_reg) + gras_pkg::BASE_W'(hi_reg);

    always_comb
    begin
        priority if (lo_reg == '0)
        begin
            pctr_next = gras_pkg::BASE_W'(hi_reg >>> 1);
        end
        else if (sum_lh[gras_pkg::BASE_W-1])
        begin
            pctr_next = sum_lh >>> 1;
        end
        else
        begin
            pctr_next = (sum_lh + 33'sd1) >>> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        // rounded half away from zero: add half the divisor before dividing
        pct_dn_reg     <= dead_x32768 - gras_pkg::PCT_PROD_W'(dead_reg) + 30'd5000;
        pct_sn_reg     <= sat_x32768 - gras_pkg::PCT_PROD_W'(sat_reg) + 30'd5000;
        pct_dp_reg     <= dead_x32768 + 30'd5000;
        pct_sp_reg     <= sat_x32768 + 30'd5000;
        thr_neg_lo_reg <= -$signed(gras_pkg::THR_W'(gras_pkg::div_pct_full(pct_sn_reg)));
        thr_neg_hi_reg <= -$signed(gras_pkg::THR_W'(gras_pkg::div_pct_full(pct_dn_reg)));
        thr_pos_lo_reg <= $signed(gras_pkg::THR_W'(gras_pkg::div_pct_full(pct_dp_reg)));
        thr_pos_hi_reg <= $signed(gras_pkg::THR_W'(gras_pkg::div_pct_full(pct_sp_reg)));
        pctr_reg       <= pctr_next;
    end

    // band selection for one stick value
    function automatic gras_pkg::mul_t prep_stick
    (
        input logic signed [gras_pkg::V_W-1:0]    v,
        input logic signed [gras_pkg::THR_W-1:0]  nlo,
        input logic signed [gras_pkg::THR_W-1:0]  nhi,
        input logic signed [gras_pkg::THR_W-1:0]  plo,
        input logic signed [gras_pkg::THR_W-1:0]  phi,
        input logic signed [gras_pkg::BASE_W-1:0] lo,
        input logic signed [gras_pkg::BASE_W-1:0] hi,
        input logic signed [gras_pkg::BASE_W-1:0] ctr
    );
        logic signed [gras_pkg::THR_W-1:0]  lmin, lmax, vx;
        logic signed [gras_pkg::BASE_W-1:0] pmin, pmax;
        logic signed [gras_pkg::MAG_W-1:0]  span;
        logic signed [gras_pkg::DIFF_W-1:0] off, den;
        gras_pkg::mul_t                     m;
        vx = gras_pkg::THR_W'(v);
        if (v[gras_pkg::V_W-1] || (v == '0))
        begin
            lmin = nlo;
            lmax = nhi;
            pmin = lo;
            pmax = ctr;
        end
        else
        begin
            lmin = plo;
            lmax = phi;
            pmin = ctr;
            pmax = hi;
        end
        span = gras_pkg::MAG_W'(pmax) - gras_pkg::MAG_W'(pmin);
        off  = gras_pkg::DIFF_W'(vx) - gras_pkg::DIFF_W'(lmin);
        den  = gras_pkg::DIFF_W'(lmax) - gras_pkg::DIFF_W'(lmin);
        priority if (vx <= lmin)
        begin
            m = '{a: '0, mag: '0, den: gras_pkg::DEN_W'(1), neg: 1'b0, base: pmin};
        end
        else if (vx >= lmax)
        begin
            m = '{a: '0, mag: '0, den: gras_pkg::DEN_W'(1), neg: 1'b0, base: pmax};
        end
        else
        begin
            m.a    = off[gras_pkg::A_W-1:0];
            m.mag  = span[gras_pkg::MAG_W-1] ? gras_pkg::MAG_W'(-span) : gras_pkg::MAG_W'(span);
            m.den  = den[gras_pkg::DEN_W-1:0];
            m.neg  = span[gras_pkg::MAG_W-1];
            m.base = pmin;
        end
        return m;
    endfunction

    // pipeline control: every stage moves while the skid register is empty
    logic                  advance;
    logic                  pipe_out_valid;
    logic [PIPE_DEPTH-1:0] stage_valid_reg;
    logic                  skid_valid_reg;
    logic                  result_valid_reg;

    assign advance        = !skid_valid_reg;
    assign report_ready   = advance;
    assign pipe_out_valid = advance && stage_valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else if (advance)
        begin
            stage_valid_reg <= {stage_valid_reg[PIPE_DEPTH-2:0], report_valid};
        end
    end

    // stage 1: capture
    gras_pkg::report_t s1_reg;

    // stage 2: centre offsets, trigger, buttons, hat
    logic signed [gras_pkg::V_W-1:0] s2_v_reg [4];
    logic        [gras_pkg::A_W-1:0] s2_trig_reg;
    gras_pkg::side_t                 s2_side_reg;
    logic signed [gras_pkg::RAW_W-1:0] s1_stick [4];
    logic        [gras_pkg::A_W-1:0] trig_a_next;

    assign s1_stick[0] = s1_reg.stick_left_x;
    assign s1_stick[1] = s1_reg.stick_left_y;
    assign s1_stick[2] = s1_reg.stick_right_x;
    assign s1_stick[3] = s1_reg.stick_right_y;

    always_comb
    begin
        priority if (s1_reg.button_bits[10])
        begin
            trig_a_next = gras_pkg::TRIG_A_HIGH;
        end
        else if (s1_reg.button_bits[11])
        begin
            trig_a_next = gras_pkg::TRIG_A_LOW;
        end
        else
        begin
            trig_a_next = gras_pkg::TRIG_A_MID;
        end
    end

    // stage 3: band selection, stage 4: product
    gras_pkg::mul_t  s3_reg [LANES];
    gras_pkg::side_t s3_side_reg;
    gras_pkg::prod_t s4_reg [LANES];
    gras_pkg::side_t s4_side_reg;
    gras_pkg::mul_t  trig_mul;
    logic signed [gras_pkg::MAG_W-1:0] trig_span;

    assign trig_span = gras_pkg::MAG_W'(hi_reg) - gras_pkg::MAG_W'(lo_reg);

    always_comb
    begin
        trig_mul.a    = s2_trig_reg;
        trig_mul.mag  = trig_span[gras_pkg::MAG_W-1] ? gras_pkg::MAG_W'(-trig_span)
                                                     : gras_pkg::MAG_W'(trig_span);
        trig_mul.den  = gras_pkg::TRIG_DEN;
        trig_mul.neg  = trig_span[gras_pkg::MAG_W-1];
        trig_mul.base = gras_pkg::BASE_W'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= report;
            for (int k = 0; k < 4; k++)
            begin
                s2_v_reg[k] <= gras_pkg::V_W'(s1_stick[k]) + 17'sd1;
            end
            s2_trig_reg <= trig_a_next;
            s2_side_reg.button_mask <= (mode_reg == gras_pkg::MODE_STANDARD)
                                       ? gras_pkg::map_buttons_std(s1_reg.button_bits)
                                       : {2'b00, s1_reg.button_bits[9:0]};
            s2_side_reg.hat_angle <= gras_pkg::hat_to_angle(s1_reg.hat_dir);

            for (int k = 0; k < 4; k++)
            begin
                s3_reg[k] <= prep_stick(s2_v_reg[k], thr_neg_lo_reg, thr_neg_hi_reg,
                                        thr_pos_lo_reg, thr_pos_hi_reg,
                                        gras_pkg::BASE_W'(lo_reg), gras_pkg::BASE_W'(hi_reg),
                                        pctr_reg);
            end
            s3_reg[4]   <= trig_mul;
            s3_side_reg <= s2_side_reg;

            for (int k = 0; k < LANES; k++)
            begin
                s4_reg[k].prod <= gras_pkg::PROD_W'(s3_reg[k].a)
                                  * gras_pkg::PROD_W'(s3_reg[k].mag);
                s4_reg[k].den  <= s3_reg[k].den;
                s4_reg[k].neg  <= s3_reg[k].neg;
                s4_reg[k].base <= s3_reg[k].base;
            end
            s4_side_reg <= s3_side_reg;
        end
    end

    // quotient pipeline: entry stage adds half the divisor, then one bit per stage
    gras_pkg::lane_t dv_reg      [DIV_STAGES+1][LANES];
    gras_pkg::side_t dv_side_reg [DIV_STAGES+1];
    logic [gras_pkg::PROD_W-1:0] num [LANES];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            num[k] = s4_reg[k].prod + gras_pkg::PROD_W'(s4_reg[k].den >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                dv_reg[0][k].rem  <= num[k][gras_pkg::PROD_W-1:gras_pkg::QUO_W];
                dv_reg[0][k].quo  <= num[k][gras_pkg::QUO_W-1:0];
                dv_reg[0][k].den  <= s4_reg[k].den;
                dv_reg[0][k].neg  <= s4_reg[k].neg;
                dv_reg[0][k].base <= s4_reg[k].base;
            end
            dv_side_reg[0] <= s4_side_reg;
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    dv_reg[j][k] <= gras_pkg::div_step(dv_reg[j-1][k]);
                end
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    // final sign and offset, layout selection
    logic signed [gras_pkg::AXIS_W-1:0] ax [LANES];
    gras_pkg::result_t                  pipe_result;
    gras_pkg::result_t                  result_reg, skid_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            ax[k] = gras_pkg::finish_lane(dv_reg[DIV_STAGES][k]);
        end
        pipe_result.axis_x      = ax[0];
        pipe_result.axis_y      = ax[1];
        pipe_result.button_mask = dv_side_reg[DIV_STAGES].button_mask;
        pipe_result.hat_angle   = dv_side_reg[DIV_STAGES].hat_angle;
        if (mode_reg == gras_pkg::MODE_STANDARD)
        begin
            pipe_result.axis_z  = ax[2];
            pipe_result.axis_rx = '0;
            pipe_result.axis_ry = '0;
            pipe_result.axis_rz = ax[3];
        end
        else
        begin
            pipe_result.axis_z  = ax[4];
            pipe_result.axis_rx = ax[2];
            pipe_result.axis_ry = ax[3];
            pipe_result.axis_rz = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (!result_valid_reg || result_ready)
        begin
            result_valid_reg <= skid_valid_reg || pipe_out_valid;
            skid_valid_reg   <= 1'b0;
        end
        else if (pipe_out_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || result_ready)
        begin
            result_reg <= skid_valid_reg ? skid_reg : pipe_result;
        end
        else if (pipe_out_valid)
        begin
            skid_reg <= pipe_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // an item leaving the pipeline is never dropped
    a_exit_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_out_valid |=> result_valid_reg)
        else $error("pipeline item lost at the output");

    // the skid register only holds while the output register is full
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register full with empty output");

    // the skid register fills only when the output transfer was held off
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result_valid_reg && !result_ready))
        else $error("skid register filled without a stalled output");

endmodule

### dv/gamepad_report_axis_scaler_tb.sv
// testbench for gamepad_report_axis_scaler: directed and random reports against a predictor
// depends on gras_pkg and the gamepad_report_axis_scaler rtl
`timescale 1ns / 100ps

module gamepad_report_axis_scaler_tb;

    // an index past the register list, writes to it are dropped
    localparam logic [gras_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;

    class axis_scoreboard;
        gras_pkg::result_t expected_q[$];
        int      errors;
        int      reports_seen;
        int      results_seen;
        bit      mode;
        longint  dead;
        longint  sat;
        longint  lo;
        longint  hi;

        function new();
            errors = 0;
            reports_seen = 0;
            results_seen = 0;
            mode = gras_pkg::MODE_COMBINED;
            dead = 0;
            sat = 10000;
            lo = 0;
            hi = 65535;
        endfunction

        function longint mul_div_round(longint a, longint b, longint c);
            longint p;
            p = a * b;
            if ((a < 0 && b < 0) || (a >= 0 && b >= 0))
                return (p + c / 2) / c;
            return (p - c / 2) / c;
        endfunction

        function longint centre();
            longint s;
            if (lo == 0)
            begin
                if (hi >= 0)
                    return hi / 2;
                return -((-hi + 1) / 2);
            end
            s = lo + hi;
            if (s >= 0)
                return (s + 1) / 2;
            return -((-s + 1) / 2);
        endfunction

        function logic [31:0] scale_stick(logic signed [15:0] raw);
            longint v;
            longint pmin;
            longint pmax;
            longint lmin;
            longint lmax;
            v = longint'(raw) + 1;
            pmin = lo;
            pmax = hi;
            if (v <= 0)
            begin
                lmax = mul_div_round(-32767, dead, gras_pkg::PCT_FULL);
                lmin = mul_div_round(-32767, sat, gras_pkg::PCT_FULL);
                pmax = centre();
            end
            else
            begin
                lmin = mul_div_round(32768, dead, gras_pkg::PCT_FULL);
                lmax = mul_div_round(32768, sat, gras_pkg::PCT_FULL);
                pmin = centre();
            end
            if (v <= lmin)
                return pmin[31:0];
            if (v >= lmax)
                return pmax[31:0];
            v = pmin + mul_div_round(v - lmin, pmax - pmin, lmax - lmin);
            return v[31:0];
        endfunction

        function void note_report(gras_pkg::report_t r);
            gras_pkg::result_t e;
            longint  trig;
            longint  t;
            e = '0;
            e.axis_x = scale_stick(r.stick_left_x);
            e.axis_y = scale_stick(r.stick_left_y);
            if (mode == gras_pkg::MODE_STANDARD)
            begin
                e.axis_z = scale_stick(r.stick_right_x);
                e.axis_rz = scale_stick(r.stick_right_y);
                for (int i = 0; i < gras_pkg::BUTTON_W; i++)
                    if (r.button_bits[i])
                        e.button_mask[gras_pkg::STD_BUTTON_MAP[i]] = 1'b1;
            end
            else
            begin
                e.axis_rx = scale_stick(r.stick_right_x);
                e.axis_ry = scale_stick(r.stick_right_y);
                trig = r.button_bits[10] ? 32767 : (r.button_bits[11] ? -32768 : 0);
                t = lo + mul_div_round(trig + 32768, hi - lo, 65535);
                e.axis_z = t[31:0];
                e.button_mask = {2'b00, r.button_bits[9:0]};
            end
            if (r.hat_dir < 0)
                e.hat_angle = -16'sd1;
            else
                e.hat_angle = 16'(int'(r.hat_dir) * gras_pkg::HAT_STEP);
            expected_q.push_back(e);
            reports_seen++;
        endfunction

        function void check_result(gras_pkg::result_t got);
            gras_pkg::result_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.axis_x !== e.axis_x)
                $display("%0t: axis_x exp %0d got %0d", $time, e.axis_x, got.axis_x);
            if (got.axis_y !== e.axis_y)
                $display("%0t: axis_y exp %0d got %0d", $time, e.axis_y, got.axis_y);
            if (got.axis_z !== e.axis_z)
                $display("%0t: axis_z exp %0d got %0d", $time, e.axis_z, got.axis_z);
            if (got.axis_rx !== e.axis_rx)
                $display("%0t: axis_rx exp %0d got %0d", $time, e.axis_rx, got.axis_rx);
            if (got.axis_ry !== e.axis_ry)
                $display("%0t: axis_ry exp %0d got %0d", $time, e.axis_ry, got.axis_ry);
            if (got.axis_rz !== e.axis_rz)
                $display("%0t: axis_rz exp %0d got %0d", $time, e.axis_rz, got.axis_rz);
            if (got.button_mask !== e.button_mask)
                $display("%0t: button_mask exp %h got %h", $time, e.button_mask,
                         got.button_mask);
            if (got.hat_angle !== e.hat_angle)
                $display("%0t: hat_angle exp %0d got %0d", $time, e.hat_angle, got.hat_angle);
            if (got !== e)
                errors++;
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gras_pkg::ADDR_W-1:0]   paddr;
    logic [gras_pkg::DATA_W-1:0]   pwdata;
    logic [gras_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          report_valid;
    logic                          report_ready;
    gras_pkg::report_t             report;
    logic                          result_valid;
    logic                          result_ready;
    gras_pkg::result_t             result;

    axis_scoreboard board;
    int             send_idle_pct;
    int             take_idle_pct;
    longint         cycles = 0;
    int             settings_run;

    gamepad_report_axis_scaler uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // result side: random stall, check on each transfer
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && result_valid && result_ready)
            board.check_result(result);
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= take_idle_pct);

    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("gamepad_report_axis_scaler test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [gras_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= gras_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            gras_pkg::REG_MODE:       board.mode = value[0];
            gras_pkg::REG_DEADZONE:   board.dead = value[13:0];
            gras_pkg::REG_SATURATION: board.sat = value[13:0];
            gras_pkg::REG_RANGE_LOW:  board.lo = longint'($signed(value));
            gras_pkg::REG_RANGE_HIGH: board.hi = longint'($signed(value));
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // entered and left at a falling edge; valid stays up into the next report
    task automatic send_report(gras_pkg::report_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            report_valid <= 1'b0;
            @(negedge clk);
        end
        report_valid <= 1'b1;
        report <= r;
        @(posedge clk);
        while (!report_ready)
            @(posedge clk);
        board.note_report(r);
        @(negedge clk);
    endtask

    task automatic drain();
        report_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_stick();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_reports(int count);
        gras_pkg::report_t r;
        for (int i = 0; i < count; i++)
        begin
            r.button_bits = 12'($urandom);
            r.hat_dir = 4'($urandom);
            r.stick_left_x = pick_stick();
            r.stick_left_y = pick_stick();
            r.stick_right_x = pick_stick();
            r.stick_right_y = pick_stick();
            send_report(r);
        end
    endtask

    task automatic configure(bit m, int dz, int st, int l, int h);
        write_reg(gras_pkg::REG_MODE, {31'b0, m});
        write_reg(gras_pkg::REG_DEADZONE, 32'(dz));
        write_reg(gras_pkg::REG_SATURATION, 32'(st));
        write_reg(gras_pkg::REG_RANGE_LOW, 32'(l));
        write_reg(gras_pkg::REG_RANGE_HIGH, 32'(h));
    endtask

    initial
    begin
        gras_pkg::report_t r;
        board = new();
        settings_run = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        report_valid = 1'b0;
        report = '0;
        result_ready = 1'b0;
        send_idle_pct = 16;
        take_idle_pct = 77;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings (combined layout)
        r = '0;
        r.hat_dir = -4'sd1;
        send_report(r);
        for (int h = -8; h < 8; h++)
        begin
            r.hat_dir = 4'(h);
            r.button_bits = 12'(1 << (h + 8) % 12);
            r.stick_left_x = (h & 1) ? 16'h8000 : 16'h7fff;
            r.stick_left_y = 16'(h);
            r.stick_right_x = 16'hffff;
            r.stick_right_y = 16'h0000;
            send_report(r);
        end
        // both triggers, the low trigger (button 11) alone, then all buttons
        r.button_bits = 12'hc00;
        send_report(r);
        r.button_bits = 12'h800;
        send_report(r);
        r.button_bits = 12'hfff;
        send_report(r);
        drain();

        // standard layout with a deadzone
        configure(gras_pkg::MODE_STANDARD, 1500, 9000, -1000, 1000);
        settings_run++;
        random_reports(120);
        drain();
        // saturation below deadzone
        configure(gras_pkg::MODE_COMBINED, 6000, 2000, 100, 300);
        settings_run++;
        random_reports(100);
        drain();
        send_idle_pct = 77;
        take_idle_pct = 16;
        // out-of-range percentages and full-width inverted range
        configure(gras_pkg::MODE_STANDARD, 16383, 16383, 32'h7fffffff, 32'h80000000);
        settings_run++;
        random_reports(100);
        drain();
        configure(gras_pkg::MODE_COMBINED, 0, 0, 32'h80000000, 32'h7fffffff);
        settings_run++;
        random_reports(150);
        drain();
        // zero low end with negative high, and an idle write beyond the register list
        configure(gras_pkg::MODE_STANDARD, 10000, 10000, 0, -77777);
        write_reg(REG_SPARE, 32'hffffffff);
        settings_run++;
        random_reports(100);
        drain();
        send_idle_pct = 0;
        take_idle_pct = 0;
        configure(gras_pkg::MODE_COMBINED, 500, 9500, -5, 5);
        settings_run++;
        random_reports(200);
        drain();
        configure(gras_pkg::MODE_STANDARD, 250, 10000, 0, 65535);
        settings_run++;
        random_reports(260);
        drain();

        $display("%0d reports, %0d results over %0d register settings",
                 board.reports_seen, board.results_seen, settings_run + 1);
        $display("covered both layouts, stick extremes, all hat values and range corners");
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("gamepad_report_axis_scaler test passed");
        else
            $display("gamepad_report_axis_scaler test failed");
        $finish;
    end
endmodule
